>>> hw/rtl/clm_pkg.sv
package clm_pkg;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] Nul     = 8'h00;

  localparam int unsigned NumWords = 10;
  localparam int unsigned WordMax  = 11;
  localparam int unsigned IdxW     = 4;

  // Command word table, zero padded to the longest word.
  localparam logic [7:0] WordChars [NumWords][WordMax] = '{
    '{"r", "g", "b", Nul, Nul, Nul, Nul, Nul, Nul, Nul, Nul},
    '{"l", "e", "d", Nul, Nul, Nul, Nul, Nul, Nul, Nul, Nul},
    '{"c", "l", "s", Nul, Nul, Nul, Nul, Nul, Nul, Nul, Nul},
    '{"p", "r", "i", "n", "t", Nul, Nul, Nul, Nul, Nul, Nul},
    '{"c", "o", "l", "o", "r", Nul, Nul, Nul, Nul, Nul, Nul},
    '{"p", "o", "t", Nul, Nul, Nul, Nul, Nul, Nul, Nul, Nul},
    '{"h", "e", "l", "p", Nul, Nul, Nul, Nul, Nul, Nul, Nul},
    '{"t", "e", "m", "p", "e", "r", "a", "t", "u", "r", "a"},
    '{"l", "e", "d", "e", "x", "t", "e", "r", "n", "o", Nul},
    '{"b", "u", "z", "z", "e", "r", Nul, Nul, Nul, Nul, Nul}
  };

  localparam int unsigned WordLen [NumWords] = '{3, 3, 3, 5, 5, 3, 4, 11, 10, 6};

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_SPACE,
    OP_CR
  } op_e;

  typedef enum logic [1:0] {
    KIND_ECHO    = 2'd0,
    KIND_PARAM1  = 2'd1,
    KIND_PARAM2  = 2'd2,
    KIND_VERDICT = 2'd3
  } kind_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } cmd_t;

endpackage

>>> hw/rtl/clm_front.sv
module clm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [7:0]        rx_char_i,
  output logic              full_o,
  output logic              q_valid_o,
  output clm_pkg::cmd_t     q_cmd_o,
  input  logic              q_pop_i
);

  clm_pkg::cmd_t entry_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    count_q;
  clm_pkg::cmd_t in_cmd;
  logic          do_push, do_pop;

  always_comb begin
    in_cmd.ch = rx_char_i;
    if (rx_char_i == clm_pkg::ChCr) begin
      in_cmd.op = clm_pkg::OP_CR;
    end else if (rx_char_i == clm_pkg::ChSpace) begin
      in_cmd.op = clm_pkg::OP_SPACE;
    end else begin
      in_cmd.op = clm_pkg::OP_CHAR;
    end
  end

  assign full_o    = (count_q == 2'd2);
  assign q_valid_o = (count_q != 2'd0);
  assign q_cmd_o   = entry_q[rptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= in_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

>>> hw/rtl/clm_back.sv
module clm_back #(
  parameter int unsigned BUF_LEN = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  clm_pkg::cmd_t             q_cmd_i,
  output logic                      q_pop_o,
  input  logic                      pop_i,
  output logic                      empty_o,
  output logic [1:0]                kind_o,
  output logic [7:0]                data_byte_o,
  output logic                      command_found_o,
  output logic [clm_pkg::IdxW-1:0]  command_index_o,
  output logic                      last_o
);

  localparam int unsigned LW       = $clog2(BUF_LEN + 1);
  localparam int unsigned AW       = $clog2(BUF_LEN);
  localparam int unsigned MemDepth = 2 ** (AW + 1);
  localparam logic [LW-1:0] BufLen  = LW'(BUF_LEN);
  localparam logic [LW-1:0] WordTop = LW'(clm_pkg::WordMax);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT,
    S_VERDICT
  } state_e;

  typedef enum logic [1:0] {
    M_CMD,
    M_P1,
    M_P2
  } mode_e;

  state_e                      state_q;
  mode_e                       mode_q;
  logic [LW-1:0]               cmd_len_q, match_len_q, len1_q, len2_q, cnt_q;
  logic                        term_q, ovf_q, sel_q;
  logic [clm_pkg::NumWords-1:0] cand_q;
  logic [7:0]                  rdata_q;
  logic [7:0]                  mem_q [MemDepth];

  logic                        ov_q, found_q, last_q;
  clm_pkg::kind_e              kind_q;
  logic [7:0]                  data_q;
  logic [clm_pkg::IdxW-1:0]    index_q;

  logic                        out_free;
  logic                        out_load;
  logic [clm_pkg::NumWords-1:0] hit;
  logic                        v_found;
  logic [clm_pkg::IdxW-1:0]    v_index;
  logic [LW-1:0]               wlen, rd_len;
  logic                        mem_we, mem_re;
  logic [AW:0]                 waddr, raddr;

  assign out_free = !ov_q || pop_i;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i && out_free;
  assign out_load = (q_pop_o && (q_cmd_i.op != clm_pkg::OP_CR)) ||
                    (((state_q == S_EMIT) || (state_q == S_VERDICT)) && out_free);

  // Each candidate survives only while every stored command byte matches its word.
  always_comb begin
    for (int i = 0; i < clm_pkg::NumWords; i++) begin
      hit[i] = (match_len_q < WordTop) &&
               (clm_pkg::WordChars[i][match_len_q[3:0]] == q_cmd_i.ch);
    end
  end

  always_comb begin
    v_found = 1'b0;
    v_index = '0;
    for (int i = clm_pkg::NumWords - 1; i >= 0; i--) begin
      if (cand_q[i] && (LW'(clm_pkg::WordLen[i]) == match_len_q)) begin
        v_found = 1'b1;
        v_index = clm_pkg::IdxW'(i);
      end
    end
    if (ovf_q) begin
      v_found = 1'b0;
      v_index = '0;
    end
  end

  assign wlen   = (mode_q == M_P2) ? len2_q : len1_q;
  assign rd_len = sel_q ? len2_q : len1_q;
  assign mem_we = q_pop_o && (q_cmd_i.op == clm_pkg::OP_CHAR) && (mode_q != M_CMD) &&
                  (wlen < BufLen);
  assign waddr  = {mode_q == M_P2, wlen[AW-1:0]};
  assign mem_re = (state_q == S_READ) && (cnt_q < rd_len);
  assign raddr  = {sel_q, cnt_q[AW-1:0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= q_cmd_i.ch;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_CMD;
      cmd_len_q   <= '0;
      match_len_q <= '0;
      len1_q      <= '0;
      len2_q      <= '0;
      cnt_q       <= '0;
      term_q      <= 1'b0;
      ovf_q       <= 1'b0;
      sel_q       <= 1'b0;
      cand_q      <= '1;
      ov_q        <= 1'b0;
      kind_q      <= clm_pkg::KIND_ECHO;
      data_q      <= '0;
      found_q     <= 1'b0;
      index_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      if (pop_i && ov_q && !out_load) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            if (q_cmd_i.op == clm_pkg::OP_CR) begin
              sel_q   <= 1'b0;
              cnt_q   <= '0;
              state_q <= S_READ;
            end else begin
              ov_q    <= 1'b1;
              kind_q  <= clm_pkg::KIND_ECHO;
              data_q  <= q_cmd_i.ch;
              found_q <= 1'b0;
              index_q <= '0;
              last_q  <= 1'b1;
              if (q_cmd_i.op == clm_pkg::OP_SPACE) begin
                mode_q <= (mode_q == M_CMD) ? M_P1 : M_P2;
              end else begin
                case (mode_q)
                  M_P1: begin
                    if (len1_q < BufLen) begin
                      len1_q <= len1_q + 1'b1;
                    end
                  end
                  M_P2: begin
                    if (len2_q < BufLen) begin
                      len2_q <= len2_q + 1'b1;
                    end
                  end
                  default: begin
                    if (cmd_len_q < BufLen) begin
                      cmd_len_q <= cmd_len_q + 1'b1;
                      if (!term_q) begin
                        if (q_cmd_i.ch == clm_pkg::Nul) begin
                          term_q <= 1'b1;
                        end else begin
                          cand_q      <= cand_q & hit;
                          match_len_q <= match_len_q + 1'b1;
                        end
                      end
                    end else begin
                      ovf_q <= 1'b1;
                    end
                  end
                endcase
              end
            end
          end
        end
        S_READ: begin
          if (cnt_q < rd_len) begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_EMIT;
          end else if (!sel_q) begin
            sel_q <= 1'b1;
            cnt_q <= '0;
          end else begin
            state_q <= S_VERDICT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            ov_q    <= 1'b1;
            kind_q  <= sel_q ? clm_pkg::KIND_PARAM2 : clm_pkg::KIND_PARAM1;
            data_q  <= rdata_q;
            found_q <= 1'b0;
            index_q <= '0;
            last_q  <= 1'b0;
            state_q <= S_READ;
          end
        end
        S_VERDICT: begin
          if (out_free) begin
            ov_q        <= 1'b1;
            kind_q      <= clm_pkg::KIND_VERDICT;
            data_q      <= '0;
            found_q     <= v_found;
            index_q     <= v_index;
            last_q      <= 1'b1;
            mode_q      <= M_CMD;
            cmd_len_q   <= '0;
            match_len_q <= '0;
            len1_q      <= '0;
            len2_q      <= '0;
            term_q      <= 1'b0;
            ovf_q       <= 1'b0;
            cand_q      <= '1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign empty_o         = !ov_q;
  assign kind_o          = kind_q;
  assign data_byte_o     = data_q;
  assign command_found_o = found_q;
  assign command_index_o = index_q;
  assign last_o          = last_q;

endmodule

>>> hw/rtl/command_line_token_matcher.sv
// Command line token matcher.
// Input queue side: present a terminal character on rx_char_i with push; it
// is taken on a clock edge where full is low. A two-beat queue sits behind
// the input, so characters can be taken on consecutive cycles.
// Result queue side: while empty is low the oldest result is on the output
// ports, and pop takes it. Every character except carriage return yields
// one echo beat, registered from the input queue, one per cycle while pop
// keeps the result queue free and no carriage return is being replayed.
// A carriage return yields the first parameter bytes, the second parameter
// bytes and a verdict beat with last_o set; replay reads each stored byte
// from the parameter RAM in S_READ and emits it in S_EMIT, and then loads
// the verdict in S_VERDICT; no new character is taken until it is loaded.
// The verdict names the matching word of a ten-word table, or not found.
// A stalled result queue holds its beat; the parser waits on it, and the
// input queue fills and then raises full.
// Reset clears the parse state and both queues; no clearing pass is needed.
module command_line_token_matcher #(
  parameter int unsigned BUF_LEN = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  input  logic [7:0]                rx_char_i,
  output logic                      full,
  input  logic                      pop,
  output logic                      empty,
  output logic [1:0]                kind_o,
  output logic [7:0]                data_byte_o,
  output logic                      command_found_o,
  output logic [clm_pkg::IdxW-1:0]  command_index_o,
  output logic                      last_o
);

  logic          q_valid, q_pop;
  clm_pkg::cmd_t q_cmd;

  clm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .rx_char_i (rx_char_i),
    .full_o    (full),
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  clm_back #(
    .BUF_LEN (BUF_LEN)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_cmd_i         (q_cmd),
    .q_pop_o         (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .command_found_o (command_found_o),
    .command_index_o (command_index_o),
    .last_o          (last_o)
  );

endmodule

>>> hw/rtl/clm_checker.sv
module clm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pop,
  input logic       empty,
  input logic [1:0] kind_o,
  input logic [7:0] data_byte_o,
  input logic       command_found_o,
  input logic [3:0] command_index_o,
  input logic       last_o
);

  // Only an echo or a verdict closes the run of beats for one character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_o == ((kind_o == clm_pkg::KIND_ECHO) ||
                           (kind_o == clm_pkg::KIND_VERDICT))))
    else $error("last flag does not match beat kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (kind_o != clm_pkg::KIND_VERDICT)) |->
      (!command_found_o && (command_index_o == 4'd0)))
    else $error("verdict fields set on a byte beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (kind_o == clm_pkg::KIND_VERDICT)) |->
      ((data_byte_o == 8'd0) && (command_index_o <= 4'd9) &&
       (command_found_o || (command_index_o == 4'd0))))
    else $error("malformed verdict beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(kind_o) && $stable(data_byte_o) &&
                          $stable(last_o)))
    else $error("stalled result beat changed");

endmodule

bind command_line_token_matcher clm_checker u_clm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pop             (pop),
  .empty           (empty),
  .kind_o          (kind_o),
  .data_byte_o     (data_byte_o),
  .command_found_o (command_found_o),
  .command_index_o (command_index_o),
  .last_o          (last_o)
);
